### sv/mahcr_pkg.sv
`default_nettype none
package mahcr_pkg;

  typedef enum logic {
    OP_PARK = 1'b0,
    OP_RAMP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_COOLDOWN    = 3'd1,
    CFG_CUR_STEP    = 3'd2,
    CFG_CUR_MAX     = 3'd3,
    CFG_RISE_PERIOD = 3'd4,
    CFG_FALL_PERIOD = 3'd5,
    CFG_RISE_AMOUNT = 3'd6,
    CFG_FALL_AMOUNT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic       park;
    logic [2:0] hall;
  } item_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] cooldown_ticks;
    logic [14:0] current_step;
    logic [14:0] current_max;
    logic [15:0] rise_period;
    logic [15:0] fall_period;
    logic [14:0] rise_amount;
    logic [14:0] fall_amount;
  } cfg_t;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam cfg_t CfgReset = '{
    debounce_ticks: 8'd25,
    cooldown_ticks: 16'd24000,
    current_step:   15'd1024,
    current_max:    15'd16384,
    rise_period:    16'd1,
    fall_period:    16'd1,
    rise_amount:    15'd10,
    fall_amount:    15'd10
  };

  localparam logic [14:0] LimitMax   = 15'h7FFF;
  localparam logic [15:0] DivCntMax  = 16'hFFFF;
  localparam logic [4:0]  StepOffset = 5'd4;
  localparam logic [3:0]  RevTrigger = 4'd3;
  localparam logic [3:0]  RevCap     = 4'd10;

  function automatic logic [2:0] fwd_next(input logic [2:0] h);
    logic [2:0] r;
    case (h)
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd6;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] rev_next(input logic [2:0] h);
    logic [2:0] r;
    case (h)
      3'd1:    r = 3'd5;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd6;
      3'd5:    r = 3'd4;
      3'd6:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/mahcr_front.sv
`default_nettype none
module mahcr_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 action_i,
  input  wire                 park_input_i,
  input  wire  [2:0]          hall_state_i,
  output logic                q_valid_o,
  output mahcr_pkg::item_t    q_item_o,
  input  wire                 q_pop_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  mahcr_pkg::item_t    mem_q [QDepth];
  mahcr_pkg::item_t    item;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  always_comb begin
    item.op   = action_i ? mahcr_pkg::OP_RAMP : mahcr_pkg::OP_PARK;
    item.park = park_input_i;
    item.hall = hall_state_i;
  end

  assign in_stall_o = (cnt_q == CntW'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count overflow");

endmodule
`default_nettype wire

### sv/mahcr_back.sv
`default_nettype none
module mahcr_back #(
  parameter int unsigned MAX_STEPS = 25
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mahcr_pkg::cfg_t     cfg_i,
  input  wire                 q_valid_i,
  input  mahcr_pkg::item_t    q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [14:0]         current_limit_o,
  output logic                hold_active_o,
  output logic [4:0]          step_count_o,
  output logic                move_dir_o,
  output logic                cooling_down_o,
  output logic [3:0]          reversal_count_o
);

  localparam logic [4:0] MaxSteps = 5'(MAX_STEPS);

  logic        out_valid_q, out_valid_d;
  logic        hold_q, hold_d;
  logic [7:0]  on_deb_q, on_deb_d, off_deb_q, off_deb_d;
  logic [2:0]  origin_q, origin_d;
  logic [4:0]  steps_q, steps_d;
  logic        dir_q, dir_d;
  // last history entry written at the current step index
  logic [2:0]  prev_q, prev_d;
  logic [3:0]  rev_q, rev_d;
  logic        last_dir_q, last_dir_d;
  logic        cool_q, cool_d;
  logic [15:0] cool_cnt_q, cool_cnt_d;
  logic [14:0] limit_q, limit_d;
  logic [15:0] rise_cnt_q, rise_cnt_d, fall_cnt_q, fall_cnt_d;

  logic        fire, engage;
  logic [2:0]  ahead, back;
  logic [4:0]  step_new;
  logic [19:0] prod;
  logic [14:0] target;
  logic [15:0] rise_sum;

  assign fire    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = fire;

  assign prod     = {15'd0, steps_q - mahcr_pkg::StepOffset} * {5'd0, cfg_i.current_step};
  assign rise_sum = {1'b0, limit_q} + {1'b0, cfg_i.rise_amount};
  assign ahead    = dir_q ? mahcr_pkg::fwd_next(prev_q) : mahcr_pkg::rev_next(prev_q);
  assign back     = dir_q ? mahcr_pkg::rev_next(prev_q) : mahcr_pkg::fwd_next(prev_q);

  always_comb begin
    out_valid_d = fire ? 1'b1 : (out_stall_i && out_valid_q);
    hold_d      = hold_q;
    on_deb_d    = on_deb_q;
    off_deb_d   = off_deb_q;
    origin_d    = origin_q;
    steps_d     = steps_q;
    dir_d       = dir_q;
    prev_d      = prev_q;
    rev_d       = rev_q;
    last_dir_d  = last_dir_q;
    cool_d      = cool_q;
    cool_cnt_d  = cool_cnt_q;
    limit_d     = limit_q;
    rise_cnt_d  = rise_cnt_q;
    fall_cnt_d  = fall_cnt_q;
    engage      = 1'b0;
    step_new    = steps_q;
    target      = '0;

    if (fire) begin
      unique case (q_item_i.op)
        mahcr_pkg::OP_PARK: begin
          if (!q_item_i.park) begin
            if (hold_q) begin
              off_deb_d = '0;
            end else if (on_deb_q >= cfg_i.debounce_ticks) begin
              engage     = 1'b1;
              origin_d   = q_item_i.hall;
              steps_d    = '0;
              dir_d      = 1'b0;
              rev_d      = '0;
              last_dir_d = 1'b0;
              hold_d     = 1'b1;
            end else begin
              on_deb_d = on_deb_q + 8'd1;
            end
          end else begin
            if (hold_q) begin
              if (off_deb_q >= cfg_i.debounce_ticks) begin
                hold_d = 1'b0;
              end else begin
                off_deb_d = off_deb_q + 8'd1;
              end
            end else begin
              on_deb_d = '0;
            end
          end

          // tracking only when hold was already on (an engage leaves hall at origin)
          if (hold_d && !engage) begin
            if (steps_q == '0) begin
              if (q_item_i.hall != origin_q) begin
                steps_d = 5'd1;
                prev_d  = q_item_i.hall;
                if (q_item_i.hall == mahcr_pkg::fwd_next(origin_q)) begin
                  dir_d = 1'b1;
                end else if (q_item_i.hall == mahcr_pkg::rev_next(origin_q)) begin
                  dir_d = 1'b0;
                end
              end
            end else if (q_item_i.hall != prev_q) begin
              if (q_item_i.hall == ahead) begin
                step_new = steps_q + 5'd1;
              end else if (q_item_i.hall == back) begin
                step_new = steps_q - 5'd1;
              end
              if (step_new > MaxSteps) begin
                steps_d = MaxSteps;
              end else begin
                steps_d = step_new;
                prev_d  = q_item_i.hall;
              end
            end
          end

          if (hold_d) begin
            if (!cool_q) begin
              if (rev_d > mahcr_pkg::RevTrigger) begin
                cool_cnt_d = '0;
                cool_d     = 1'b1;
              end
            end else if (cool_cnt_q >= cfg_i.cooldown_ticks) begin
              cool_d     = 1'b0;
              steps_d    = '0;
              last_dir_d = 1'b0;
              rev_d      = '0;
            end else begin
              cool_cnt_d = cool_cnt_q + 16'd1;
            end
          end
        end

        mahcr_pkg::OP_RAMP: begin
          if (steps_q >= mahcr_pkg::StepOffset) begin
            if (rev_q == '0) begin
              last_dir_d = dir_q;
              rev_d      = 4'd1;
            end else if (dir_q != last_dir_q) begin
              if (rev_q <= mahcr_pkg::RevCap) begin
                rev_d = rev_q + 4'd1;
              end
              last_dir_d = dir_q;
            end
            target = (prod > {5'd0, cfg_i.current_max}) ? cfg_i.current_max : prod[14:0];
          end

          if (target > limit_q) begin
            if (rise_cnt_q > cfg_i.rise_period) begin
              rise_cnt_d = '0;
              limit_d    = rise_sum[15] ? mahcr_pkg::LimitMax : rise_sum[14:0];
            end else if (rise_cnt_q != mahcr_pkg::DivCntMax) begin
              rise_cnt_d = rise_cnt_q + 16'd1;
            end
          end else if (target < limit_q) begin
            if (fall_cnt_q > cfg_i.fall_period) begin
              fall_cnt_d = '0;
              limit_d    = (cfg_i.fall_amount >= limit_q) ? '0 : limit_q - cfg_i.fall_amount;
            end else if (fall_cnt_q != mahcr_pkg::DivCntMax) begin
              fall_cnt_d = fall_cnt_q + 16'd1;
            end
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_q      <= 1'b0;
      on_deb_q    <= '0;
      off_deb_q   <= '0;
      origin_q    <= '0;
      steps_q     <= '0;
      dir_q       <= 1'b0;
      prev_q      <= '0;
      rev_q       <= '0;
      last_dir_q  <= 1'b0;
      cool_q      <= 1'b0;
      cool_cnt_q  <= '0;
      limit_q     <= '0;
      rise_cnt_q  <= '0;
      fall_cnt_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      hold_q      <= hold_d;
      on_deb_q    <= on_deb_d;
      off_deb_q   <= off_deb_d;
      origin_q    <= origin_d;
      steps_q     <= steps_d;
      dir_q       <= dir_d;
      prev_q      <= prev_d;
      rev_q       <= rev_d;
      last_dir_q  <= last_dir_d;
      cool_q      <= cool_d;
      cool_cnt_q  <= cool_cnt_d;
      limit_q     <= limit_d;
      rise_cnt_q  <= rise_cnt_d;
      fall_cnt_q  <= fall_cnt_d;
    end
  end

  // state registers double as the output word; they only move when the slot is free
  assign out_valid_o      = out_valid_q;
  assign current_limit_o  = limit_q;
  assign hold_active_o    = hold_q;
  assign step_count_o     = steps_q;
  assign move_dir_o       = dir_q;
  assign cooling_down_o   = cool_q;
  assign reversal_count_o = rev_q;

  a_steps_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= MaxSteps)
    else $error("step count above clamp");

  a_rev_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_q <= (mahcr_pkg::RevCap + 4'd1))
    else $error("reversal count above cap");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(limit_q) && $stable(steps_q) && $stable(hold_q))
    else $error("state moved without a word");

  a_cool_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cool_q) |-> $past(fire) && $past(q_item_i.op == mahcr_pkg::OP_PARK))
    else $error("cooldown started outside a park tick");

endmodule
`default_nettype wire

### sv/motor_auto_hold_current_ramp.sv
// A word accepted into the two-entry queue is executed by the back end once the output
// slot is free; the state registers it updates form the output word, held until taken.
// Throughput: one word per cycle unless the output stalls; each word is one park or
// ramp tick. A stalled output holds the back end, the queue fills, then input stalls.
// Reset (async, active low) clears all hold, tracking, cooldown and ramp
// state and loads the configuration registers with their defaults.
`default_nettype none
module motor_auto_hold_current_ramp #(
  parameter int unsigned MAX_STEPS = 25
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [mahcr_pkg::CfgAddrW-1:0]   cfg_idx_i,
  input  wire  [mahcr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              action_i,
  input  wire                              park_input_i,
  input  wire  [2:0]                       hall_state_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [14:0]                      current_limit_o,
  output logic                             hold_active_o,
  output logic [4:0]                       step_count_o,
  output logic                             move_dir_o,
  output logic                             cooling_down_o,
  output logic [3:0]                       reversal_count_o
);

  mahcr_pkg::cfg_t  cfg_q, cfg_d;
  mahcr_pkg::item_t q_item;
  logic             q_valid, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mahcr_pkg::cfg_idx_e'(cfg_idx_i))
        mahcr_pkg::CFG_DEBOUNCE:    cfg_d.debounce_ticks = cfg_wdata_i[7:0];
        mahcr_pkg::CFG_COOLDOWN:    cfg_d.cooldown_ticks = cfg_wdata_i;
        mahcr_pkg::CFG_CUR_STEP:    cfg_d.current_step   = cfg_wdata_i[14:0];
        mahcr_pkg::CFG_CUR_MAX:     cfg_d.current_max    = cfg_wdata_i[14:0];
        mahcr_pkg::CFG_RISE_PERIOD: cfg_d.rise_period    = cfg_wdata_i;
        mahcr_pkg::CFG_FALL_PERIOD: cfg_d.fall_period    = cfg_wdata_i;
        mahcr_pkg::CFG_RISE_AMOUNT: cfg_d.rise_amount    = cfg_wdata_i[14:0];
        mahcr_pkg::CFG_FALL_AMOUNT: cfg_d.fall_amount    = cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mahcr_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mahcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .park_input_i (park_input_i),
    .hall_state_i (hall_state_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  mahcr_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .current_limit_o  (current_limit_o),
    .hold_active_o    (hold_active_o),
    .step_count_o     (step_count_o),
    .move_dir_o       (move_dir_o),
    .cooling_down_o   (cooling_down_o),
    .reversal_count_o (reversal_count_o)
  );

endmodule
`default_nettype wire

### bench/tb_motor_auto_hold_current_ramp.sv
module tb_motor_auto_hold_current_ramp;

  localparam int unsigned MAX_STEPS   = 25;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // successor tables, entry h at bits [3h +: 3]
  localparam logic [23:0] HALL_AHEAD  = {3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0};
  localparam logic [23:0] HALL_BEHIND = {3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd0};
  // forward rotation 1,3,2,6,4,5
  localparam logic [17:0] WALK_RING   = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

  typedef struct {
    logic [14:0] limit;
    logic        hold;
    logic [4:0]  steps;
    logic        dir;
    logic        cool;
    logic [3:0]  revs;
  } hold_status_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [mahcr_pkg::CfgAddrW-1:0] cfg_idx_i = '0;
  logic [mahcr_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           action_i = 1'b0;
  logic                           park_input_i = 1'b1;
  logic [2:0]                     hall_state_i = 3'd0;
  logic                           out_stall_i = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [14:0]                    current_limit_o;
  logic                           hold_active_o;
  logic [4:0]                     step_count_o;
  logic                           move_dir_o;
  logic                           cooling_down_o;
  logic [3:0]                     reversal_count_o;

  motor_auto_hold_current_ramp #(.MAX_STEPS(MAX_STEPS)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .park_input_i    (park_input_i),
    .hall_state_i    (hall_state_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_limit_o (current_limit_o),
    .hold_active_o   (hold_active_o),
    .step_count_o    (step_count_o),
    .move_dir_o      (move_dir_o),
    .cooling_down_o  (cooling_down_o),
    .reversal_count_o(reversal_count_o)
  );

  mahcr_pkg::item_t tick_q[$];
  hold_status_t     status_q[$];
  int unsigned      mismatches = 0;
  int unsigned      idle_pct = 0;
  int unsigned      send_gap = 0;
  int unsigned      stall_left = 0;
  int unsigned      cycles = 0;

  // predictor state
  mahcr_pkg::cfg_t cfg_m = mahcr_pkg::CfgReset;
  logic        engaged = 1'b0;
  logic [7:0]  arm_cnt = '0;
  logic [7:0]  drop_cnt = '0;
  logic [2:0]  home_hall = '0;
  logic [4:0]  disp = '0;
  logic        fwd_dir = 1'b0;
  logic [3:0]  rev_seen = '0;
  logic        rev_dir = 1'b0;
  logic        cool_on = 1'b0;
  logic [15:0] cool_cnt = '0;
  logic [14:0] lim = '0;
  logic [14:0] lim_goal = '0;
  logic [15:0] up_cnt = '0;
  logic [15:0] down_cnt = '0;
  logic [2:0]  trail [32];

  // stimulus walker
  int unsigned walk_pos = 0;
  logic        walk_fwd = 1'b1;
  int unsigned leg_left = 6;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[motor_auto_hold_current_ramp] ERROR");
      $finish;
    end
  end

  function automatic logic [2:0] hall_ahead_of(logic [2:0] h);
    return HALL_AHEAD[h*3 +: 3];
  endfunction

  function automatic logic [2:0] hall_behind_of(logic [2:0] h);
    return HALL_BEHIND[h*3 +: 3];
  endfunction

  task automatic predict_hold_ramp(mahcr_pkg::op_e op, logic park, logic [2:0] hall);
    logic [2:0]   prev;
    logic [2:0]   ahead;
    logic [2:0]   back;
    int unsigned  prod;
    int unsigned  sum;
    hold_status_t r;
    if (op == mahcr_pkg::OP_PARK) begin
      if (!park) begin
        if (engaged) begin
          drop_cnt = '0;
        end else if (arm_cnt >= cfg_m.debounce_ticks) begin
          home_hall = hall;
          disp      = '0;
          fwd_dir   = 1'b0;
          rev_seen  = '0;
          rev_dir   = 1'b0;
          engaged   = 1'b1;
        end else begin
          arm_cnt += 1;
        end
      end else begin
        if (engaged) begin
          if (drop_cnt >= cfg_m.debounce_ticks) engaged = 1'b0;
          else drop_cnt += 1;
        end else begin
          arm_cnt = '0;
        end
      end
      if (engaged) begin
        if (disp == 0) begin
          if (hall != home_hall) begin
            disp     = 5'd1;
            trail[1] = hall;
            if (hall == hall_ahead_of(home_hall)) fwd_dir = 1'b1;
            else if (hall == hall_behind_of(home_hall)) fwd_dir = 1'b0;
          end
        end else begin
          prev = trail[disp];
          if (hall != prev) begin
            ahead = fwd_dir ? hall_ahead_of(prev) : hall_behind_of(prev);
            back  = fwd_dir ? hall_behind_of(prev) : hall_ahead_of(prev);
            if (hall == ahead) disp += 1;
            else if (hall == back) disp -= 1;
            trail[disp] = hall;
          end
          if (disp > MAX_STEPS) disp = MAX_STEPS;
        end
        if (!cool_on) begin
          if (rev_seen > mahcr_pkg::RevTrigger) begin
            cool_cnt = '0;
            cool_on  = 1'b1;
          end
        end else if (cool_cnt >= cfg_m.cooldown_ticks) begin
          cool_on  = 1'b0;
          disp     = '0;
          rev_dir  = 1'b0;
          rev_seen = '0;
        end else begin
          cool_cnt += 1;
        end
      end
    end else begin
      if (disp < mahcr_pkg::StepOffset) begin
        lim_goal = '0;
      end else begin
        if (rev_seen == 0) begin
          rev_dir  = fwd_dir;
          rev_seen = 4'd1;
        end else if (fwd_dir != rev_dir) begin
          if (rev_seen <= mahcr_pkg::RevCap) rev_seen += 1;
          rev_dir = fwd_dir;
        end
        prod     = (int'(disp) - 4) * int'(cfg_m.current_step);
        lim_goal = (prod > cfg_m.current_max) ? cfg_m.current_max : prod[14:0];
      end
      if (lim_goal > lim) begin
        if (up_cnt > cfg_m.rise_period) begin
          up_cnt = '0;
          sum    = lim + cfg_m.rise_amount;
          lim    = (sum > mahcr_pkg::LimitMax) ? mahcr_pkg::LimitMax : sum[14:0];
        end else if (up_cnt != mahcr_pkg::DivCntMax) begin
          up_cnt += 1;
        end
      end else if (lim_goal < lim) begin
        if (down_cnt > cfg_m.fall_period) begin
          down_cnt = '0;
          lim      = (cfg_m.fall_amount >= lim) ? '0 : lim - cfg_m.fall_amount;
        end else if (down_cnt != mahcr_pkg::DivCntMax) begin
          down_cnt += 1;
        end
      end
    end
    r.limit = lim;
    r.hold  = engaged;
    r.steps = disp;
    r.dir   = fwd_dir;
    r.cool  = cool_on;
    r.revs  = rev_seen;
    status_q.push_back(r);
  endtask

  task automatic cmp_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin : drive_words
    mahcr_pkg::item_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        predict_hold_ramp(mahcr_pkg::op_e'(action_i), park_input_i, hall_state_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap   <= $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          w            = tick_q.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= w.op;
          park_input_i <= w.park;
          hall_state_i <= w.hall;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_results
    hold_status_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          if (mismatches < 40)
            $display("%0t: result word with nothing expected, expected none, actual limit %0d",
                     $time, current_limit_o);
          mismatches++;
        end else begin
          e = status_q.pop_front();
          cmp_field("current_limit", e.limit, current_limit_o);
          cmp_field("hold_active", e.hold, hold_active_o);
          cmp_field("step_count", e.steps, step_count_o);
          cmp_field("move_dir", e.dir, move_dir_o);
          cmp_field("cooling_down", e.cool, cooling_down_o);
          cmp_field("reversal_count", e.revs, reversal_count_o);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_word(mahcr_pkg::op_e op, logic park, logic [2:0] hall);
    mahcr_pkg::item_t w;
    w.op   = op;
    w.park = park;
    w.hall = hall;
    tick_q.push_back(w);
  endtask

  task automatic put_reg(mahcr_pkg::cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic apply_settings(int unsigned deb, int unsigned cool, int unsigned step,
                                int unsigned cmax, int unsigned rp, int unsigned fp,
                                int unsigned ra, int unsigned fa);
    put_reg(mahcr_pkg::CFG_DEBOUNCE, deb[15:0]);
    put_reg(mahcr_pkg::CFG_COOLDOWN, cool[15:0]);
    put_reg(mahcr_pkg::CFG_CUR_STEP, step[15:0]);
    put_reg(mahcr_pkg::CFG_CUR_MAX, cmax[15:0]);
    put_reg(mahcr_pkg::CFG_RISE_PERIOD, rp[15:0]);
    put_reg(mahcr_pkg::CFG_FALL_PERIOD, fp[15:0]);
    put_reg(mahcr_pkg::CFG_RISE_AMOUNT, ra[15:0]);
    put_reg(mahcr_pkg::CFG_FALL_AMOUNT, fa[15:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_m.debounce_ticks = deb[7:0];
    cfg_m.cooldown_ticks = cool[15:0];
    cfg_m.current_step   = step[14:0];
    cfg_m.current_max    = cmax[14:0];
    cfg_m.rise_period    = rp[15:0];
    cfg_m.fall_period    = fp[15:0];
    cfg_m.rise_amount    = ra[14:0];
    cfg_m.fall_amount    = fa[14:0];
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || status_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly well-formed hall rotation with drifting direction, plus glitches,
  // ramp ticks and park release bursts
  task automatic walk_hall(int unsigned n, int unsigned rel_pct);
    int unsigned made;
    int unsigned k;
    int unsigned r;
    logic        step_fwd;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_word(mahcr_pkg::OP_RAMP, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        made++;
      end else if (r < 30 + rel_pct) begin
        k = $urandom_range(1, (cfg_m.debounce_ticks + 2 > 40) ? 40 : cfg_m.debounce_ticks + 2);
        repeat (k) add_word(mahcr_pkg::OP_PARK, 1'b1, WALK_RING[walk_pos*3 +: 3]);
        made += k;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          add_word(mahcr_pkg::OP_PARK, 1'b0, 3'($urandom_range(0, 7)));
        end else begin
          if (r >= 14) begin
            if (leg_left == 0) begin
              walk_fwd = !walk_fwd;
              leg_left = $urandom_range(2, 30);
            end
            leg_left--;
            step_fwd = ($urandom_range(0, 9) == 0) ? !walk_fwd : walk_fwd;
            if (step_fwd) walk_pos = (walk_pos == 5) ? 0 : walk_pos + 1;
            else walk_pos = (walk_pos == 0) ? 5 : walk_pos - 1;
          end
          add_word(mahcr_pkg::OP_PARK, 1'b0, WALK_RING[walk_pos*3 +: 3]);
        end
        made++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 20;
    apply_settings(0, 2, 32767, 32767, 0, 0, 32767, 32767);
    add_word(mahcr_pkg::OP_RAMP, 1'b1, 3'd7);
    add_word(mahcr_pkg::OP_PARK, 1'b1, 3'd1);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd1);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd3);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd2);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd6);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd4);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd5);
    add_word(mahcr_pkg::OP_RAMP, 1'b0, 3'd0);
    add_word(mahcr_pkg::OP_RAMP, 1'b1, 3'd5);
    add_word(mahcr_pkg::OP_RAMP, 1'b0, 3'd2);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd0);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd7);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd5);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd4);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd6);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd2);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd3);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd1);
    add_word(mahcr_pkg::OP_PARK, 1'b0, 3'd5);
    add_word(mahcr_pkg::OP_RAMP, 1'b1, 3'd1);
    add_word(mahcr_pkg::OP_RAMP, 1'b0, 3'd6);
    add_word(mahcr_pkg::OP_PARK, 1'b1, 3'd5);
    add_word(mahcr_pkg::OP_PARK, 1'b1, 3'd6);
    add_word(mahcr_pkg::OP_RAMP, 1'b1, 3'd3);
    drain();

    idle_pct = 25;
    apply_settings(0, 0, 1024, 16384, 1, 1, 10, 10);
    walk_hall(90, 3);
    drain();

    idle_pct = 40;
    apply_settings(3, 20, 32767, 32767, 0, 0, 32767, 1);
    walk_hall(90, 2);
    drain();

    idle_pct = 15;
    apply_settings(255, 65535, 0, 0, 65535, 65535, 0, 0);
    walk_hall(80, 0);
    drain();

    idle_pct = 0;
    apply_settings(1, 5, 2000, 30000, 2, 3, 500, 700);
    walk_hall(90, 3);
    drain();

    idle_pct = 30;
    apply_settings(2, 40, 100, 1500, 0, 5, 3000, 50);
    walk_hall(90, 2);
    drain();

    idle_pct = 25;
    apply_settings(0, 10, 5000, 20000, 1, 0, 40, 9000);
    walk_hall(90, 3);
    drain();

    idle_pct = 35;
    apply_settings($urandom_range(0, 6), $urandom_range(0, 60), $urandom_range(0, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 4), $urandom_range(0, 4),
                   $urandom_range(0, 32767), $urandom_range(0, 32767));
    walk_hall(90, 2);
    drain();

    idle_pct = 0;
    apply_settings(0, 12, 1024, 16384, 1, 1, 10, 10);
    walk_hall(90, 2);
    drain();

    if (mismatches == 0) begin
      $display("[motor_auto_hold_current_ramp] OK");
    end else begin
      $display("[motor_auto_hold_current_ramp] ERROR");
    end
    $finish;
  end

endmodule
